// File: hw/rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;

    localparam int PROD_W  = 2 * PCT_W;
    localparam int TRI_W   = 6;
    localparam int NUM_W   = 20;
    localparam int SCL_W   = 24;
    localparam int QUO_W   = 18;
    localparam int RCP_W   = 19;
    localparam int RCP_SH  = 28;

    localparam logic [HUE_W-1:0]  HUE_FULL  = 9'd360;
    localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
    localparam logic [RCP_W-1:0]  RECIP_625 = 19'd429497;

    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;

    typedef logic [2:0]        sector_t;
    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [QUO_W-1:0]  quo_t;
    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        num_t full;
        num_t rise;
        num_t base;
    } num_trio_t;

endpackage

// File: hw/rtl/hsv_to_rgb_color_convert.sv
`timescale 1ns / 1ps

// An accepted input transaction passes through the registered stages below to its output transaction.
// Throughput: one transaction per cycle; a stalled output holds every stage in place.
// Stages: clamp and sector, two percent products, channel numerators, scale by 17/64,
// one reciprocal multiply per channel, and the sector select into the output register.
// Reset clears the stage valid bits only; data registers are not reset.

module hsv_to_rgb_color_convert
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              hsv_valid,
    output logic                              hsv_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]      hue,
    input  logic [hsvrgb_pkg::PCT_W-1:0]      saturation,
    input  logic [hsvrgb_pkg::PCT_W-1:0]      value,
    output logic                              rgb_valid,
    input  logic                              rgb_ready,
    output logic [hsvrgb_pkg::COLOR_W-1:0]    color
);

    import hsvrgb_pkg::*;

    logic                  advance;

    logic [HUE_W-1:0]      hue_wrap;
    logic [PCT_W-1:0]      sat_clamp;
    logic [PCT_W-1:0]      val_clamp;
    sector_t               sector_next;
    logic [PCT_W-1:0]      span_pos;
    logic [PCT_W-1:0]      tri_wide;

    logic                  s1_valid_reg;
    logic [PCT_W-1:0]      s1_sat_reg;
    logic [PCT_W-1:0]      s1_val_reg;
    logic [TRI_W-1:0]      s1_tri_reg;
    sector_t               s1_sector_reg;

    logic                  s2_valid_reg;
    logic [PROD_W-1:0]     s2_chroma_reg;
    logic [PROD_W-1:0]     s2_offset_reg;
    logic [PCT_W-1:0]      s2_val_reg;
    logic [TRI_W-1:0]      s2_tri_reg;
    sector_t               s2_sector_reg;

    num_trio_t             s3_num_next;
    logic                  s3_valid_reg;
    num_trio_t             s3_num_reg;
    sector_t               s3_sector_reg;

    logic [SCL_W-1:0]      scl_full;
    logic [SCL_W-1:0]      scl_rise;
    logic [SCL_W-1:0]      scl_base;
    logic                  s4_valid_reg;
    quo_t                  s4_full_reg;
    quo_t                  s4_rise_reg;
    quo_t                  s4_base_reg;
    sector_t               s4_sector_reg;

    logic [QUO_W+RCP_W-1:0] prod_full;
    logic [QUO_W+RCP_W-1:0] prod_rise;
    logic [QUO_W+RCP_W-1:0] prod_base;
    logic                  s5_valid_reg;
    chan_t                 s5_full_reg;
    chan_t                 s5_rise_reg;
    chan_t                 s5_base_reg;
    sector_t               s5_sector_reg;

    logic [COLOR_W-1:0]    color_next;
    logic                  out_valid_reg;
    logic [COLOR_W-1:0]    color_reg;

    assign advance   = !out_valid_reg || rgb_ready;
    assign hsv_ready = advance;
    assign rgb_valid = out_valid_reg;
    assign color     = color_reg;

    always_comb
    begin
        hue_wrap  = (hue >= HUE_FULL) ? (hue - HUE_FULL) : hue;
        sat_clamp = (saturation > PCT_MAX) ? PCT_MAX : saturation;
        val_clamp = (value > PCT_MAX) ? PCT_MAX : value;

        if (hue_wrap >= 9'd300)
            sector_next = SEC_MAG_RED;
        else if (hue_wrap >= 9'd240)
            sector_next = SEC_BLU_MAG;
        else if (hue_wrap >= 9'd180)
            sector_next = SEC_CYN_BLU;
        else if (hue_wrap >= 9'd120)
            sector_next = SEC_GRN_CYN;
        else if (hue_wrap >= 9'd60)
            sector_next = SEC_YEL_GRN;
        else
            sector_next = SEC_RED_YEL;

        if (hue_wrap >= 9'd240)
            span_pos = PCT_W'(hue_wrap - 9'd240);
        else if (hue_wrap >= 9'd120)
            span_pos = PCT_W'(hue_wrap - 9'd120);
        else
            span_pos = PCT_W'(hue_wrap);

        tri_wide = (span_pos >= 7'd60) ? (7'd120 - span_pos) : span_pos;
    end

    always_comb
    begin
        s3_num_next.full = NUM_W'(s2_val_reg) * NUM_W'(6000);
        s3_num_next.base = NUM_W'(s2_offset_reg) * NUM_W'(60);
        s3_num_next.rise = NUM_W'(s2_chroma_reg) * NUM_W'(s2_tri_reg)
                         + NUM_W'(s2_offset_reg) * NUM_W'(60);
    end

    always_comb
    begin
        scl_full = {s3_num_reg.full, 4'b0000} + {4'b0000, s3_num_reg.full};
        scl_rise = {s3_num_reg.rise, 4'b0000} + {4'b0000, s3_num_reg.rise};
        scl_base = {s3_num_reg.base, 4'b0000} + {4'b0000, s3_num_reg.base};
    end

    always_comb
    begin
        prod_full = (QUO_W+RCP_W)'(s4_full_reg) * (QUO_W+RCP_W)'(RECIP_625);
        prod_rise = (QUO_W+RCP_W)'(s4_rise_reg) * (QUO_W+RCP_W)'(RECIP_625);
        prod_base = (QUO_W+RCP_W)'(s4_base_reg) * (QUO_W+RCP_W)'(RECIP_625);
    end

    always_comb
    begin
        case (s5_sector_reg)
            SEC_RED_YEL: color_next = {s5_full_reg, s5_rise_reg, s5_base_reg};
            SEC_YEL_GRN: color_next = {s5_rise_reg, s5_full_reg, s5_base_reg};
            SEC_GRN_CYN: color_next = {s5_base_reg, s5_full_reg, s5_rise_reg};
            SEC_CYN_BLU: color_next = {s5_base_reg, s5_rise_reg, s5_full_reg};
            SEC_BLU_MAG: color_next = {s5_rise_reg, s5_base_reg, s5_full_reg};
            default:     color_next = {s5_full_reg, s5_base_reg, s5_rise_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= hsv_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sat_reg    <= sat_clamp;
            s1_val_reg    <= val_clamp;
            s1_tri_reg    <= TRI_W'(tri_wide);
            s1_sector_reg <= sector_next;

            s2_chroma_reg <= PROD_W'(s1_val_reg) * PROD_W'(s1_sat_reg);
            s2_offset_reg <= PROD_W'(s1_val_reg) * PROD_W'(PCT_MAX - s1_sat_reg);
            s2_val_reg    <= s1_val_reg;
            s2_tri_reg    <= s1_tri_reg;
            s2_sector_reg <= s1_sector_reg;

            s3_num_reg    <= s3_num_next;
            s3_sector_reg <= s2_sector_reg;

            s4_full_reg   <= scl_full[SCL_W-1:6];
            s4_rise_reg   <= scl_rise[SCL_W-1:6];
            s4_base_reg   <= scl_base[SCL_W-1:6];
            s4_sector_reg <= s3_sector_reg;

            s5_full_reg   <= prod_full[RCP_SH+CHAN_W-1:RCP_SH];
            s5_rise_reg   <= prod_rise[RCP_SH+CHAN_W-1:RCP_SH];
            s5_base_reg   <= prod_base[RCP_SH+CHAN_W-1:RCP_SH];
            s5_sector_reg <= s4_sector_reg;

            color_reg     <= color_next;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg,
                              s4_valid_reg, s5_valid_reg, out_valid_reg}))
        else $error("pipeline valid bits moved during a stall");

    a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_sat_reg <= PCT_MAX && s1_val_reg <= PCT_MAX &&
                          s1_tri_reg <= 6'd60 && s1_sector_reg <= SEC_MAG_RED))
        else $error("first stage holds an out-of-range operand");

    a_num_order: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_num_reg.base <= s3_num_reg.rise &&
                          s3_num_reg.rise <= s3_num_reg.full &&
                          s3_num_reg.full <= NUM_W'(600000)))
        else $error("channel numerators out of order");

endmodule

// File: tb/tb_hsv_to_rgb_color_convert.sv
`timescale 1ns / 1ps

module tb_hsv_to_rgb_color_convert;

    import hsvrgb_pkg::*;

    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PER_MIX = 157;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
    } hsv_item_t;

    typedef struct {
        hsv_item_t          pixel;
        logic [COLOR_W-1:0] color;
    } color_expect_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                hsv_valid = 1'b0;
    logic                hsv_ready;
    logic [HUE_W-1:0]    hue = '0;
    logic [PCT_W-1:0]    saturation = '0;
    logic [PCT_W-1:0]    value = '0;
    logic                rgb_valid;
    logic                rgb_ready = 1'b0;
    logic [COLOR_W-1:0]  color;

    hsv_item_t     pending_hsv_q[$];
    color_expect_t expected_color_q[$];
    hsv_item_t     drv_item;
    color_expect_t got_expect;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int error_count   = 0;
    int colors_seen   = 0;
    int idle_cycles   = 0;
    int hold_cnt      = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;

    hsv_to_rgb_color_convert i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsv_valid  (hsv_valid),
        .hsv_ready  (hsv_ready),
        .hue        (hue),
        .saturation (saturation),
        .value      (value),
        .rgb_valid  (rgb_valid),
        .rgb_ready  (rgb_ready),
        .color      (color)
    );

    always #5 clk = ~clk;

    function automatic logic [COLOR_W-1:0] hsv_to_color(hsv_item_t px);
        int unsigned hh;
        int unsigned ss;
        int unsigned vv;
        int unsigned ramp;
        int unsigned chroma;
        int unsigned second;
        int unsigned offset;
        int unsigned rn;
        int unsigned gn;
        int unsigned bn;
        sector_t     sec;
        logic [CHAN_W-1:0] rc;
        logic [CHAN_W-1:0] gc;
        logic [CHAN_W-1:0] bc;
        hh = 32'(px.hue);
        ss = 32'(px.sat);
        vv = 32'(px.val);
        if (hh >= 32'(HUE_FULL))
        begin
            hh = hh - 32'(HUE_FULL);
        end
        if (ss > 32'(PCT_MAX))
        begin
            ss = 32'(PCT_MAX);
        end
        if (vv > 32'(PCT_MAX))
        begin
            vv = 32'(PCT_MAX);
        end
        ramp   = hh % 120;
        ramp   = (ramp >= 60) ? (120 - ramp) : ramp;
        chroma = vv * ss * 60;
        second = vv * ss * ramp;
        offset = vv * (100 - ss) * 60;
        sec    = sector_t'(hh / 60);
        case (sec)
            SEC_RED_YEL: begin rn = chroma; gn = second; bn = 0;      end
            SEC_YEL_GRN: begin rn = second; gn = chroma; bn = 0;      end
            SEC_GRN_CYN: begin rn = 0;      gn = chroma; bn = second; end
            SEC_CYN_BLU: begin rn = 0;      gn = second; bn = chroma; end
            SEC_BLU_MAG: begin rn = second; gn = 0;      bn = chroma; end
            default:     begin rn = chroma; gn = 0;      bn = second; end
        endcase
        rc = CHAN_W'((255 * (rn + offset)) / 600000);
        gc = CHAN_W'((255 * (gn + offset)) / 600000);
        bc = CHAN_W'((255 * (bn + offset)) / 600000);
        return {rc, gc, bc};
    endfunction

    function automatic hsv_item_t random_pixel();
        hsv_item_t px;
        if ($urandom_range(0, 99) < 80)
        begin
            px.hue = HUE_W'($urandom_range(0, 359));
            px.sat = PCT_W'($urandom_range(0, 100));
            px.val = PCT_W'($urandom_range(0, 100));
        end
        else
        begin
            px.hue = HUE_W'($urandom);
            px.sat = PCT_W'($urandom);
            px.val = PCT_W'($urandom);
        end
        return px;
    endfunction

    task automatic add_pixel(int h, int s, int v);
        hsv_item_t px;
        px.hue = HUE_W'(h);
        px.sat = PCT_W'(s);
        px.val = PCT_W'(v);
        pending_hsv_q.push_back(px);
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_hsv_q.size() != 0 || hsv_valid || expected_color_q.size() != 0);
    endtask

    task automatic run_random_mix(int n, int send_pct, int stall_in);
        send_idle_pct = send_pct;
        stall_pct     = stall_in;
        repeat (n)
        begin
            pending_hsv_q.push_back(random_pixel());
        end
        wait_drained();
    endtask

    // Driver: a new transaction is offered only after the previous one is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_valid  <= 1'b0;
            hue        <= '0;
            saturation <= '0;
            value      <= '0;
        end
        else
        begin
            if (hsv_valid && hsv_ready)
            begin
                got_expect.pixel.hue = hue;
                got_expect.pixel.sat = saturation;
                got_expect.pixel.val = value;
                got_expect.color     = hsv_to_color(got_expect.pixel);
                expected_color_q.push_back(got_expect);
            end
            if (!hsv_valid || hsv_ready)
            begin
                if (pending_hsv_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drv_item    = pending_hsv_q.pop_front();
                    hsv_valid  <= 1'b1;
                    hue        <= drv_item.hue;
                    saturation <= drv_item.sat;
                    value      <= drv_item.val;
                end
                else
                begin
                    hsv_valid <= 1'b0;
                end
            end
        end
    end

    // Output ready, with a single long hold-off that lets the pipeline back up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_ready <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            rgb_ready <= 1'b0;
            hold_cnt  <= hold_cnt + 1;
            if (hold_cnt == LONG_HOLD - 1)
            begin
                hold_done <= 1'b1;
            end
        end
        else
        begin
            rgb_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rgb_valid && rgb_ready)
        begin
            colors_seen++;
            if (expected_color_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("%0t: unexpected color transaction 0x%06h", $realtime, color);
                end
            end
            else
            begin
                color_expect_t exp_c;
                exp_c = expected_color_q.pop_front();
                if (color !== exp_c.color)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("%0t: hue %0d sat %0d val %0d: expected 0x%06h, got 0x%06h",
                                 $realtime, exp_c.pixel.hue, exp_c.pixel.sat,
                                 exp_c.pixel.val, exp_c.color, color);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hsv_valid && hsv_ready) || (rgb_valid && rgb_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_pixel(0, 100, 100);
        add_pixel(59, 100, 100);
        add_pixel(60, 100, 100);
        add_pixel(119, 100, 100);
        add_pixel(120, 100, 100);
        add_pixel(179, 100, 100);
        add_pixel(180, 100, 100);
        add_pixel(239, 100, 100);
        add_pixel(240, 100, 100);
        add_pixel(299, 100, 100);
        add_pixel(300, 100, 100);
        add_pixel(359, 100, 100);
        add_pixel(360, 100, 100);
        add_pixel(511, 100, 100);
        add_pixel(0, 0, 0);
        add_pixel(200, 0, 100);
        add_pixel(200, 100, 0);
        add_pixel(90, 101, 127);
        add_pixel(330, 127, 101);
        add_pixel(45, 50, 50);
        add_pixel(150, 37, 83);
        add_pixel(270, 1, 1);
        add_pixel(420, 64, 99);
        wait_drained();

        hold_req = 1'b1;
        run_random_mix(RANDOM_PER_MIX, 0, 0);
        run_random_mix(RANDOM_PER_MIX, 49, 0);
        run_random_mix(RANDOM_PER_MIX, 0, 49);
        run_random_mix(RANDOM_PER_MIX, 12, 12);

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d colors: sector edges, hue wrap, percent clamps and random pixels,",
                 colors_seen);
        $display("under four flow-control mixes including a %0d-cycle output hold.", LONG_HOLD);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: hsv_to_rgb_color_convert.f
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsv_to_rgb_color_convert.sv
tb/tb_hsv_to_rgb_color_convert.sv
